@@ hw/rtl/sbcr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbcr_pkg
// Types and constants shared by the scrolling bitmap column renderer.
// ----------------------------------------------------------------------------
package sbcr_pkg;

    localparam int DEF_BYTES_PER_ROW = 5;
    localparam int ROWS              = 8;
    localparam int WIDTH_BITS        = 6;
    localparam int COLOR_BITS        = 24;
    localparam int LED_BITS          = 7;
    localparam int APB_ADDR_BITS     = 3;
    localparam int APB_DATA_BITS     = 32;

    localparam logic REG_BITMAP_WIDTH = 1'b0;

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_RENDER = 1'b1
    } t_command;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WAIT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load_wr;
        logic render_start;
        logic rd_issue;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic is_render;
        logic in_range;
        logic rd_last;
        logic mask_empty;
        logic mask_last;
        logic out_free;
    } t_dp_status;

endpackage
`default_nettype wire

@@ hw/rtl/sbcr_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbcr_if
// Valid/ready channels for command items and pixel items.
// ----------------------------------------------------------------------------
interface sbcr_cmd_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [2:0]  row_number;
    logic [2:0]  byte_number;
    logic [7:0]  byte_value;
    logic [3:0]  screen_column;
    logic signed [15:0] scroll_offset;
    logic [23:0] draw_color;

    modport source (
        output valid, command, row_number, byte_number, byte_value,
               screen_column, scroll_offset, draw_color,
        input  ready
    );
    modport sink (
        input  valid, command, row_number, byte_number, byte_value,
               screen_column, scroll_offset, draw_color,
        output ready
    );
endinterface

interface sbcr_pix_if;
    logic        valid;
    logic        ready;
    logic [6:0]  led_index;
    logic [23:0] pixel_color;
    logic        last_pixel;

    modport source (
        output valid, led_index, pixel_color, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, led_index, pixel_color, last_pixel,
        output ready
    );
endinterface
`default_nettype wire

@@ hw/rtl/scroll_bitmap_column_render.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scroll_bitmap_column_render
// Scrolling text column renderer for a 16x8 matrix of two 8x8 panels.
// ----------------------------------------------------------------------------
// Channel   Direction  Protocol    Item
// i_cmd     in         valid/ready load byte or render column command
// o_pix     out        valid/ready LED index, color, last flag
// APB       in         psel/penable register 0: bitmap width
//
// A load or an out-of-range render is accepted in idle and needs no further state.
// A render in range makes eight reads of the single-port bitmap memory,
// waits for the last read data, then moves one lit pixel per cycle into
// the output register, stalling while it is not taken.
// Reset clears the control state and the width; the bitmap holds no reset.
// ----------------------------------------------------------------------------
module scroll_bitmap_column_render #(
    parameter int BYTES_PER_ROW = sbcr_pkg::DEF_BYTES_PER_ROW
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    sbcr_cmd_if.sink                                i_cmd,
    sbcr_pix_if.source                              o_pix,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [sbcr_pkg::APB_ADDR_BITS-1:0] paddr,
    input  wire logic [sbcr_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic      [sbcr_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                                    pready
);

    logic [sbcr_pkg::WIDTH_BITS-1:0] bitmap_width;
    sbcr_pkg::t_dp_cmd               dp_cmd;
    sbcr_pkg::t_dp_status            dp_status;

    sbcr_regs u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_bitmap_width (bitmap_width)
    );

    sbcr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .i_status   (dp_status),
        .o_in_ready (i_cmd.ready),
        .o_cmd      (dp_cmd)
    );

    sbcr_datapath #(
        .BYTES_PER_ROW (BYTES_PER_ROW)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_status        (dp_status),
        .i_command       (i_cmd.command),
        .i_row_number    (i_cmd.row_number),
        .i_byte_number   (i_cmd.byte_number),
        .i_byte_value    (i_cmd.byte_value),
        .i_screen_column (i_cmd.screen_column),
        .i_scroll_offset (i_cmd.scroll_offset),
        .i_draw_color    (i_cmd.draw_color),
        .i_bitmap_width  (bitmap_width),
        .i_out_ready     (o_pix.ready),
        .o_out_valid     (o_pix.valid),
        .o_led_index     (o_pix.led_index),
        .o_pixel_color   (o_pix.pixel_color),
        .o_last_pixel    (o_pix.last_pixel)
    );

endmodule
`default_nettype wire

@@ hw/rtl/sbcr_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbcr_regs
// APB register file holding the bitmap width.
// ----------------------------------------------------------------------------
module sbcr_regs (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [sbcr_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  wire logic [sbcr_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic      [sbcr_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                     pready,
    output logic      [sbcr_pkg::WIDTH_BITS-1:0]     o_bitmap_width
);

    logic [sbcr_pkg::WIDTH_BITS-1:0] r_width;
    logic                            sel_width;

    assign sel_width = (paddr[2] == sbcr_pkg::REG_BITMAP_WIDTH);
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= '0;
        end else if (psel && penable && pwrite && pready && sel_width) begin
            r_width <= pwdata[sbcr_pkg::WIDTH_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (sel_width) begin
            prdata[sbcr_pkg::WIDTH_BITS-1:0] = r_width;
        end
    end

    assign o_bitmap_width = r_width;

endmodule
`default_nettype wire

@@ hw/rtl/sbcr_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbcr_ctrl
// Sequencer: accepts an item; a render in range reads eight bitmap rows, then emits lit pixels.
// ----------------------------------------------------------------------------
module sbcr_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire sbcr_pkg::t_dp_status i_status,
    output logic                      o_in_ready,
    output sbcr_pkg::t_dp_cmd         o_cmd
);

    sbcr_pkg::t_state r_state;
    sbcr_pkg::t_state n_state;
    logic             accept;

    assign accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbcr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sbcr_pkg::S_IDLE: begin
                if (accept && i_status.is_render && i_status.in_range) begin
                    n_state = sbcr_pkg::S_READ;
                end
            end
            sbcr_pkg::S_READ: begin
                if (i_status.rd_last) begin
                    n_state = sbcr_pkg::S_WAIT;
                end
            end
            sbcr_pkg::S_WAIT: begin
                n_state = sbcr_pkg::S_EMIT;
            end
            sbcr_pkg::S_EMIT: begin
                if (i_status.mask_empty) begin
                    n_state = sbcr_pkg::S_IDLE;
                end else if (i_status.out_free && i_status.mask_last) begin
                    n_state = sbcr_pkg::S_IDLE;
                end
            end
            default: n_state = sbcr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            sbcr_pkg::S_IDLE: begin
                o_in_ready         = 1'b1;
                o_cmd.load_wr      = i_in_valid && !i_status.is_render;
                o_cmd.render_start = i_in_valid && i_status.is_render && i_status.in_range;
            end
            sbcr_pkg::S_READ: begin
                o_cmd.rd_issue = 1'b1;
            end
            sbcr_pkg::S_WAIT: begin
            end
            sbcr_pkg::S_EMIT: begin
                o_cmd.emit = !i_status.mask_empty && i_status.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

@@ hw/rtl/sbcr_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbcr_datapath
// Bitmap memory, column capture, row mask and the pixel output register.
// ----------------------------------------------------------------------------
module sbcr_datapath #(
    parameter int BYTES_PER_ROW = sbcr_pkg::DEF_BYTES_PER_ROW
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire sbcr_pkg::t_dp_cmd                 i_cmd,
    output sbcr_pkg::t_dp_status                   o_status,
    input  wire logic                              i_command,
    input  wire logic [2:0]                        i_row_number,
    input  wire logic [2:0]                        i_byte_number,
    input  wire logic [7:0]                        i_byte_value,
    input  wire logic [3:0]                        i_screen_column,
    input  wire logic signed [15:0]                i_scroll_offset,
    input  wire logic [sbcr_pkg::COLOR_BITS-1:0]   i_draw_color,
    input  wire logic [sbcr_pkg::WIDTH_BITS-1:0]   i_bitmap_width,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output logic      [sbcr_pkg::LED_BITS-1:0]     o_led_index,
    output logic      [sbcr_pkg::COLOR_BITS-1:0]   o_pixel_color,
    output logic                                   o_last_pixel
);

    localparam int Depth     = sbcr_pkg::ROWS * BYTES_PER_ROW;
    localparam int AddrWidth = $clog2(Depth);

    logic [7:0]           r_mem [Depth];
    logic [7:0]           r_rdata;
    logic [AddrWidth-1:0] r_rd_addr;
    logic [2:0]           r_row;
    logic [2:0]           r_rd_row;
    logic                 r_rd_pend;
    logic [2:0]           r_bit;
    logic [3:0]           r_column;
    logic [sbcr_pkg::COLOR_BITS-1:0] r_color;
    logic [7:0]           r_mask;

    logic                 r_out_valid;
    logic [sbcr_pkg::LED_BITS-1:0]   r_out_led;
    logic [sbcr_pkg::COLOR_BITS-1:0] r_out_color;
    logic                 r_out_last;

    logic signed [16:0]   src;
    logic [2:0]           ubyte;
    logic                 in_range;
    logic                 load_ok;
    logic [AddrWidth-1:0] wr_addr;
    logic [2:0]           low_row;
    logic [7:0]           rest_mask;
    logic                 out_free;

    assign src      = $signed({13'd0, i_screen_column}) + 17'(i_scroll_offset);
    assign ubyte    = src[5:3];
    assign in_range = !src[16] && (src[15:6] == '0) && (src[5:0] < i_bitmap_width)
                      && (32'(ubyte) < BYTES_PER_ROW);
    assign load_ok  = 32'(i_byte_number) < BYTES_PER_ROW;
    assign wr_addr  = AddrWidth'(32'(i_row_number) * BYTES_PER_ROW + 32'(i_byte_number));

    always_comb begin
        low_row = '0;
        for (int i = sbcr_pkg::ROWS - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                low_row = 3'(i);
            end
        end
    end

    assign rest_mask = r_mask & (r_mask - 8'd1);
    assign out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && load_ok) begin
            r_mem[wr_addr] <= i_byte_value;
        end
        if (i_cmd.rd_issue) begin
            r_rdata <= r_mem[r_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.render_start) begin
            r_rd_addr <= AddrWidth'(ubyte);
            r_bit     <= src[2:0];
            r_column  <= i_screen_column;
            r_color   <= i_draw_color;
        end else if (i_cmd.rd_issue) begin
            r_rd_addr <= r_rd_addr + AddrWidth'(BYTES_PER_ROW);
        end
        r_rd_row <= r_row;
        if (i_cmd.emit) begin
            r_out_led   <= {r_column[3], low_row, r_column[2:0]};
            r_out_color <= r_color;
            r_out_last  <= (rest_mask == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_rd_pend   <= 1'b0;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_pend <= i_cmd.rd_issue;
            if (i_cmd.render_start) begin
                r_row  <= '0;
                r_mask <= '0;
            end else begin
                if (i_cmd.rd_issue) begin
                    r_row <= r_row + 3'd1;
                end
                if (r_rd_pend) begin
                    r_mask[r_rd_row] <= r_rdata[3'd7 - r_bit];
                end else if (i_cmd.emit) begin
                    r_mask <= rest_mask;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status            = '0;
        o_status.is_render  = (i_command == sbcr_pkg::CMD_RENDER);
        o_status.in_range   = in_range;
        o_status.rd_last    = (r_row == 3'(sbcr_pkg::ROWS - 1));
        o_status.mask_empty = (r_mask == '0);
        o_status.mask_last  = (rest_mask == '0);
        o_status.out_free   = out_free;
    end

    assign o_out_valid   = r_out_valid;
    assign o_led_index   = r_out_led;
    assign o_pixel_color = r_out_color;
    assign o_last_pixel  = r_out_last;

    a_emit_has_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_mask != '0) && out_free)
        else $error("pixel emitted with empty mask or busy output");

    a_read_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_issue |-> (32'(r_rd_addr) < Depth))
        else $error("bitmap read beyond store");

    a_capture_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_issue |=> r_rd_pend && !i_cmd.emit)
        else $error("row capture overlaps emission");

    a_start_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.render_start |-> !i_cmd.load_wr && !i_cmd.rd_issue && !r_rd_pend)
        else $error("render start overlaps other work");

endmodule
`default_nettype wire
